[hdl/aes_sbox_pkg.sv]
// ----------------------------------------------------------------------------
// aes_sbox_pkg
// Shared widths and item types for the bitsliced AES S-box.
// ----------------------------------------------------------------------------
package aes_sbox_pkg;

	localparam int unsigned PLANE_W    = 64;
	localparam int unsigned NUM_PLANES = 8;
	localparam int unsigned NUM_LANES  = 64;

	typedef struct packed {
		logic [PLANE_W-1:0] in_plane7;
		logic [PLANE_W-1:0] in_plane6;
		logic [PLANE_W-1:0] in_plane5;
		logic [PLANE_W-1:0] in_plane4;
		logic [PLANE_W-1:0] in_plane3;
		logic [PLANE_W-1:0] in_plane2;
		logic [PLANE_W-1:0] in_plane1;
		logic [PLANE_W-1:0] in_plane0;
	} in_item_t;

	typedef struct packed {
		logic [PLANE_W-1:0] out_plane7;
		logic [PLANE_W-1:0] out_plane6;
		logic [PLANE_W-1:0] out_plane5;
		logic [PLANE_W-1:0] out_plane4;
		logic [PLANE_W-1:0] out_plane3;
		logic [PLANE_W-1:0] out_plane2;
		logic [PLANE_W-1:0] out_plane1;
		logic [PLANE_W-1:0] out_plane0;
	} out_item_t;

endpackage

[hdl/aes_sbox_core.sv]
// ----------------------------------------------------------------------------
// aes_sbox_core
// Bitsliced S-box gate network: basis change, tower-field GF(2^8) inverse,
// output basis change with the 0x63 affine constant. Purely combinational.
// ----------------------------------------------------------------------------
module aes_sbox_core
	import aes_sbox_pkg::*;
#(
	parameter int unsigned LANES = NUM_LANES
) (
	input  logic [NUM_PLANES-1:0][LANES-1:0] planes,
	output logic [NUM_PLANES-1:0][LANES-1:0] sub_planes
);

	logic [LANES-1:0] b0, b1, b2, b3, b4, b5, b6, b7;
	logic [LANES-1:0] t0, t1, t2, t3, t4, t5, t6, t7;

	always_comb begin
		b0 = planes[0]; b1 = planes[1]; b2 = planes[2]; b3 = planes[3];
		b4 = planes[4]; b5 = planes[5]; b6 = planes[6]; b7 = planes[7];

		// input basis change
		b5 = b5 ^ b6; b2 = b2 ^ b1; t0 = b0 ^ b5; b6 = b6 ^ b2; b3 = b3 ^ b0;
		b6 = b6 ^ b3; b3 = b3 ^ b7; b7 = b7 ^ t0; b3 = b3 ^ b4; b4 = b4 ^ t0;
		b3 = b3 ^ b1; b2 = b2 ^ b7; b1 = b1 ^ t0;

		// tower-field inversion
		t3 = b7 ^ b4; t2 = b1 ^ b2; t1 = t0 ^ b3; t5 = b2 ^ b4; t4 = b6 ^ b0;
		t7 = t3 ^ t2; b5 = t2 & t1; t2 = t1 | t2; t6 = t3 & t4; t3 = t4 | t3;
		t4 = t1 ^ t4; t7 = t4 & t7; t4 = b3 ^ b0; t5 = t4 & t5; t3 = t3 ^ t5;
		t2 = t2 ^ t5; t5 = b7 ^ b1; t4 = t0 ^ b6; t1 = t5 | t4; t5 = t4 & t5;
		b5 = b5 ^ t5; t3 = t3 ^ t7; t2 = t2 ^ t6; t1 = t1 ^ t7; b5 = b5 ^ t6;
		t1 = t1 ^ t6;
		t4 = b2 & b3; t5 = b4 & b0; t6 = b1 & t0; t7 = b7 | b6;
		t3 = t3 ^ t4; t2 = t2 ^ t5; t1 = t1 ^ t6; b5 = b5 ^ t7;
		t4 = t3 ^ t2; t3 = t1 & t3; t6 = b5 ^ t3; t7 = t4 & t6; t7 = t2 ^ t7;
		t5 = t1 ^ b5; t3 = t2 ^ t3; t5 = t3 & t5; t5 = b5 ^ t5; t1 = t1 ^ t5;
		t2 = t6 ^ t5; t2 = b5 & t2; t1 = t1 ^ t2; t6 = t6 ^ t2; t6 = t7 & t6;
		t6 = t4 ^ t6; t2 = t7 ^ t6; t2 = b6 & t2; t4 = b6 ^ t0; t4 = t6 & t4;
		b5 = t0 & t7; t4 = t4 ^ b5; b5 = b5 ^ t2; b6 = b6 ^ b0; t0 = t0 ^ b3;
		t7 = t7 ^ t5;
		t6 = t6 ^ t1; t3 = t7 ^ t6; t3 = b6 & t3; b6 = b6 ^ t0; b6 = t6 & b6;
		t0 = t7 & t0; t0 = t0 ^ b6; b6 = b6 ^ t3; t2 = t5 ^ t1; t2 = b0 & t2;
		b0 = b0 ^ b3; b0 = t1 & b0; b3 = b3 & t5; b0 = b0 ^ b3; b3 = b3 ^ t2;
		b0 = b0 ^ b6;
		b6 = b6 ^ t4; b3 = b3 ^ t0; t0 = t0 ^ b5; t4 = b7 ^ b4; b5 = b1 ^ b2;
		t3 = t7 ^ t6; t3 = t4 & t3; t4 = t4 ^ b5; t4 = t6 & t4; b5 = t7 & b5;
		b5 = b5 ^ t4; t4 = t4 ^ t3; t2 = t5 ^ t1; t2 = b4 & t2; b4 = b4 ^ b2;
		b4 = t1 & b4; b2 = b2 & t5; b4 = b4 ^ b2; b2 = b2 ^ t2; t7 = t7 ^ t5;
		t6 = t6 ^ t1;
		t3 = t7 ^ t6; t3 = b7 & t3; b7 = b7 ^ b1; b7 = t6 & b7; b1 = b1 & t7;
		b7 = b7 ^ b1; b1 = b1 ^ t3; b7 = b7 ^ t4; b4 = b4 ^ t4; b1 = b1 ^ b5;
		b2 = b2 ^ b5;

		// output basis change; inversions carry the 0x63 constant
		b5 = b7 ^ b0; t1 = b1 ^ b6; t2 = b4 ^ b5; t4 = b6 ^ b0;
		b0 = b0 ^ t1; b1 = t0 ^ t1; b7 = t0 ^ b2; b6 = b2 ^ b3;
		b2 = t2 ^ b7; b4 = b3 ^ b7; b3 = t4 ^ b4;

		sub_planes[0] = ~b0;
		sub_planes[1] = ~b1;
		sub_planes[2] = b2;
		sub_planes[3] = b3;
		sub_planes[4] = b4;
		sub_planes[5] = ~b5;
		sub_planes[6] = ~b6;
		sub_planes[7] = b7;
	end

endmodule

[hdl/aes_sbox_bitsliced.sv]
// ----------------------------------------------------------------------------
// aes_sbox_bitsliced
// Bitsliced AES forward S-box over LANES byte lanes, two register stages.
// ----------------------------------------------------------------------------
// Each item is eight bit-planes (plane 0 = LSB); lane L of every plane forms
// one byte, and the result is that byte through the AES S-box, same layout.
// One item is accepted per clock while in_ready is high; an accepted item
// passes the input register, the gate network and the result register
// before out_valid rises for it.
// The block keeps taking items while a result waits, stalling only when both
// stages are full and out_ready is low. Plane bits at lane positions LANES
// and above are ignored on input and driven to zero on output.
module aes_sbox_bitsliced
	import aes_sbox_pkg::*;
#(
	parameter int unsigned LANES = NUM_LANES
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic                            valid_s1, valid_s2;
	logic [NUM_PLANES-1:0][LANES-1:0] planes_s1, planes_s2;
	logic [NUM_PLANES-1:0][LANES-1:0] sub_planes;
	logic                            adv_s2, adv_s1;

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= in_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			planes_s1[0] <= in_data.in_plane0[LANES-1:0];
			planes_s1[1] <= in_data.in_plane1[LANES-1:0];
			planes_s1[2] <= in_data.in_plane2[LANES-1:0];
			planes_s1[3] <= in_data.in_plane3[LANES-1:0];
			planes_s1[4] <= in_data.in_plane4[LANES-1:0];
			planes_s1[5] <= in_data.in_plane5[LANES-1:0];
			planes_s1[6] <= in_data.in_plane6[LANES-1:0];
			planes_s1[7] <= in_data.in_plane7[LANES-1:0];
		end
		if (adv_s2 && valid_s1) planes_s2 <= sub_planes;
	end

	aes_sbox_core #(
		.LANES(LANES)
	) u_core (
		.planes    (planes_s1),
		.sub_planes(sub_planes)
	);

	assign out_valid           = valid_s2;
	assign out_data.out_plane0 = PLANE_W'(planes_s2[0]);
	assign out_data.out_plane1 = PLANE_W'(planes_s2[1]);
	assign out_data.out_plane2 = PLANE_W'(planes_s2[2]);
	assign out_data.out_plane3 = PLANE_W'(planes_s2[3]);
	assign out_data.out_plane4 = PLANE_W'(planes_s2[4]);
	assign out_data.out_plane5 = PLANE_W'(planes_s2[5]);
	assign out_data.out_plane6 = PLANE_W'(planes_s2[6]);
	assign out_data.out_plane7 = PLANE_W'(planes_s2[7]);

endmodule

[hdl/aes_sbox_checker.sv]
// ----------------------------------------------------------------------------
// aes_sbox_sva
// Port-level checks for the bitsliced S-box, bound to the top level.
// ----------------------------------------------------------------------------
module aes_sbox_sva
	import aes_sbox_pkg::*;
#(
	parameter int unsigned LANES = NUM_LANES
) (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	logic [1:0] inflight_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with no result waiting");

	a_dead_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.out_plane0 | out_data.out_plane1 |
			out_data.out_plane2 | out_data.out_plane3 | out_data.out_plane4 |
			out_data.out_plane5 | out_data.out_plane6 | out_data.out_plane7)
			>> LANES) == '0)
		else $error("unused lane bits not zero");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && inflight_q == 2'd0 |=> !out_valid ##1 out_valid)
		else $error("item into empty block not out after two cycles");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3 && (out_valid || inflight_q == 2'd0 ||
			inflight_q == 2'd1))
		else $error("item count out of range");

endmodule

bind aes_sbox_bitsliced aes_sbox_sva #(
	.LANES(LANES)
) u_aes_sbox_sva (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
